/* rtl/nta_pkg.sv */
// Package with shared types and constants of the automaton table acceptor.
`default_nettype none

package nta_pkg;

    // Field widths of the request and response words
    localparam int OP_W      = 4;
    localparam int SLOT_W    = 4;
    localparam int CHAR_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int SET_OUT_W = 10;

    // Symbol alphabet: a-z, A-Z, 0-9
    localparam int LETTER_N  = 26;
    localparam int DIGIT_N   = 10;
    localparam int SYM_N     = 2 * LETTER_N + DIGIT_N;
    localparam int SYM_IDX_W = $clog2(SYM_N);

    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = CH_LOWER_A + CHAR_W'(LETTER_N - 1);
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = CH_UPPER_A + CHAR_W'(LETTER_N - 1);
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = CH_DIGIT_0 + CHAR_W'(DIGIT_N - 1);

    localparam logic [SYM_IDX_W-1:0] UPPER_BASE = SYM_IDX_W'(LETTER_N);
    localparam logic [SYM_IDX_W-1:0] DIGIT_BASE = SYM_IDX_W'(2 * LETTER_N);

    // Command queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR        = 4'd0,
        OP_CREATE       = 4'd1,
        OP_DELETE       = 4'd2,
        OP_LINK_ADD     = 4'd3,
        OP_LINK_REMOVE  = 4'd4,
        OP_UNLINK_ALL   = 4'd5,
        OP_SET_INIT     = 4'd6,
        OP_TOGGLE_FINAL = 4'd7,
        OP_RUN_START    = 4'd8,
        OP_RUN_SYMBOL   = 4'd9,
        OP_RUN_END      = 4'd10
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_REJECTED = 2'd2,
        ST_NO_INIT  = 2'd3
    } status_t;

    // Classified command as it travels through the queue
    typedef struct packed {
        op_t                  op;
        logic [SLOT_W-1:0]    src;
        logic [SLOT_W-1:0]    dst;
        logic                 src_ok;
        logic                 dst_ok;
        logic [SYM_IDX_W-1:0] sym_idx;
        logic                 sym_ok;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_entry_t;

endpackage

`default_nettype wire

/* rtl/nta_req_if.sv */
// Request channel: one operation word per handshake.
`default_nettype none

interface nta_req_if;
    logic                        valid;
    logic                        ready;
    logic [nta_pkg::OP_W-1:0]    operation;
    logic [nta_pkg::SLOT_W-1:0]  source_state;
    logic [nta_pkg::SLOT_W-1:0]  target_state;
    logic [nta_pkg::CHAR_W-1:0]  symbol;

    modport source (output valid, operation, source_state, target_state, symbol,
                    input ready);
    modport sink (input valid, operation, source_state, target_state, symbol,
                  output ready);
endinterface

`default_nettype wire

/* rtl/nta_rsp_if.sv */
// Response channel: one result word per handshake.
`default_nettype none

interface nta_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nta_pkg::STATUS_W-1:0]  status;
    logic [nta_pkg::SLOT_W-1:0]    slot;
    logic [nta_pkg::SET_OUT_W-1:0] active_set;

    modport source (output valid, status, slot, active_set, input ready);
    modport sink (input valid, status, slot, active_set, output ready);
endinterface

`default_nettype wire

/* rtl/nta_front.sv */
// Front end: accepts request words, decodes the operation, range-checks slots, maps the symbol.
`default_nettype none

module nta_front #(
    parameter int NUM_SLOTS = 10
) (
    nta_req_if.sink              req,
    output nta_pkg::q_entry_t    push,
    input  logic                 push_ready
);
    import nta_pkg::*;

    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(NUM_SLOTS);

    assign req.ready = push_ready;

    always_comb
    begin
        push.valid       = req.valid;
        push.cmd.op      = op_t'(req.operation);
        push.cmd.src     = req.source_state;
        push.cmd.dst     = req.target_state;
        push.cmd.src_ok  = {1'b0, req.source_state} < SLOT_LIMIT;
        push.cmd.dst_ok  = {1'b0, req.target_state} < SLOT_LIMIT;
        push.cmd.sym_idx = '0;
        push.cmd.sym_ok  = 1'b1;

        // Character to symbol bit index; anything else is no symbol
        if (req.symbol inside {[CH_LOWER_A : CH_LOWER_Z]})
        begin
            push.cmd.sym_idx = SYM_IDX_W'(req.symbol - CH_LOWER_A);
        end
        else if (req.symbol inside {[CH_UPPER_A : CH_UPPER_Z]})
        begin
            push.cmd.sym_idx = SYM_IDX_W'(req.symbol - CH_UPPER_A) + UPPER_BASE;
        end
        else if (req.symbol inside {[CH_DIGIT_0 : CH_DIGIT_9]})
        begin
            push.cmd.sym_idx = SYM_IDX_W'(req.symbol - CH_DIGIT_0) + DIGIT_BASE;
        end
        else
        begin
            push.cmd.sym_ok = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/nta_queue.sv */
// Short command FIFO between the front end and the execution back end.
`default_nettype none

module nta_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nta_pkg::q_entry_t    push,
    output logic                 push_ready,
    output nta_pkg::q_entry_t    head,
    input  logic                 pop
);
    import nta_pkg::*;

    cmd_t                store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = count_reg != '0;
    assign head.cmd   = store_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/nta_back.sv */
// Back end: slot flags, transition row memory, run set simulation and the result register.
`default_nettype none

module nta_back #(
    parameter int NUM_SLOTS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nta_pkg::q_entry_t    head,
    output logic                 pop,
    nta_rsp_if.source            rsp
);
    import nta_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int ROW_W = NUM_SLOTS * SYM_N;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODIFY,
        S_SCAN,
        S_SCAN_END
    } state_t;

    // Transition rows: row i holds the symbol masks of all edges leaving slot i
    logic [ROW_W-1:0]      row_mem [NUM_SLOTS];
    logic [ROW_W-1:0]      row_rd_reg;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;

    state_t                state_reg,      state_next;
    cmd_t                  cur_reg,        cur_next;
    logic [NUM_SLOTS-1:0]  active_reg,     active_next;
    logic [NUM_SLOTS-1:0]  final_reg,      final_next;
    logic [IDX_W-1:0]      init_slot_reg,  init_slot_next;
    logic                  init_valid_reg, init_valid_next;
    logic [NUM_SLOTS-1:0]  run_set_reg,    run_set_next;
    logic [NUM_SLOTS-1:0]  ent_valid_reg  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  ent_valid_next [NUM_SLOTS];
    logic [IDX_W-1:0]      scan_idx_reg,   scan_idx_next;
    logic                  pend_reg,       pend_next;
    logic [IDX_W-1:0]      pend_row_reg,   pend_row_next;
    logic [NUM_SLOTS-1:0]  acc_reg,        acc_next;
    logic                  rsp_valid_reg;
    status_t               rsp_status_reg;
    logic [SLOT_W-1:0]     rsp_slot_reg;
    logic [SET_OUT_W-1:0]  rsp_set_reg;

    logic                  out_free;
    logic                  res_fire;
    status_t               res_status;
    logic [SLOT_W-1:0]     res_slot;
    logic [IDX_W-1:0]      hd_src;
    logic [IDX_W-1:0]      hd_dst;
    logic                  src_use;
    logic                  dst_use;
    logic [IDX_W-1:0]      free_idx;
    logic                  free_any;
    logic [NUM_SLOTS-1:0]  contrib;
    logic [IDX_W-1:0]      cur_src;
    logic [IDX_W-1:0]      cur_dst;
    logic [SYM_N-1:0]      seg_old;
    logic [SYM_N-1:0]      seg_new;
    logic [SYM_N-1:0]      sym_mask;

    assign out_free       = !rsp_valid_reg || rsp.ready;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.slot       = rsp_slot_reg;
    assign rsp.active_set = rsp_set_reg;

    assign hd_src  = head.cmd.src[IDX_W-1:0];
    assign hd_dst  = head.cmd.dst[IDX_W-1:0];
    assign src_use = head.cmd.src_ok && active_reg[hd_src];
    assign dst_use = head.cmd.dst_ok && active_reg[hd_dst];
    assign cur_src = cur_reg.src[IDX_W-1:0];
    assign cur_dst = cur_reg.dst[IDX_W-1:0];

    // Lowest inactive slot for create
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // Successors reached from the row read last cycle, if that slot is in the run set
    always_comb
    begin
        logic [SYM_N-1:0] seg;
        logic             row_hit;
        row_hit = pend_reg && run_set_reg[pend_row_reg];
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            seg        = row_rd_reg[j * SYM_N +: SYM_N];
            contrib[j] = row_hit && ent_valid_reg[pend_row_reg][j] && seg[cur_reg.sym_idx];
        end
    end

    // Link edit merge: the selected edge mask with the symbol bit set or cleared
    always_comb
    begin
        sym_mask = SYM_N'(1) << cur_reg.sym_idx;
        seg_old  = ent_valid_reg[cur_src][cur_dst] ? row_rd_reg[cur_dst * SYM_N +: SYM_N] : '0;
        seg_new  = (cur_reg.op == OP_LINK_ADD) ? (seg_old | sym_mask) : (seg_old & ~sym_mask);
        mem_wdata = row_rd_reg;
        mem_wdata[cur_dst * SYM_N +: SYM_N] = seg_new;
    end

    // Control and next state
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        active_next     = active_reg;
        final_next      = final_reg;
        init_slot_next  = init_slot_reg;
        init_valid_next = init_valid_reg;
        run_set_next    = run_set_reg;
        ent_valid_next  = ent_valid_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pend_row_next   = pend_row_reg;
        acc_next        = acc_reg;
        pop             = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = hd_src;
        mem_we          = 1'b0;
        mem_waddr       = cur_src;
        res_fire        = 1'b0;
        res_status      = ST_OK;
        res_slot        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop      = 1'b1;
                    cur_next = head.cmd;
                    case (head.cmd.op)
                        OP_CLEAR:
                        begin
                            res_fire        = 1'b1;
                            active_next     = '0;
                            final_next      = '0;
                            init_slot_next  = '0;
                            init_valid_next = 1'b0;
                            run_set_next    = '0;
                            ent_valid_next  = '{default: '0};
                        end
                        OP_CREATE:
                        begin
                            res_fire = 1'b1;
                            if (free_any)
                            begin
                                active_next[free_idx] = 1'b1;
                                final_next[free_idx]  = 1'b0;
                                res_slot              = SLOT_W'(free_idx);
                            end
                            else
                            begin
                                res_status = ST_REFUSED;
                            end
                        end
                        OP_DELETE:
                        begin
                            res_fire = 1'b1;
                            if (dst_use)
                            begin
                                active_next[hd_dst]  = 1'b0;
                                final_next[hd_dst]   = 1'b0;
                                run_set_next[hd_dst] = 1'b0;
                                if (init_slot_reg == hd_dst)
                                begin
                                    init_valid_next = 1'b0;
                                end
                                // Row and column of the slot read as empty from now on
                                for (int i = 0; i < NUM_SLOTS; i++)
                                begin
                                    ent_valid_next[i][hd_dst] = 1'b0;
                                end
                                ent_valid_next[hd_dst] = '0;
                            end
                            else
                            begin
                                res_status = ST_REFUSED;
                            end
                        end
                        OP_LINK_ADD, OP_LINK_REMOVE:
                        begin
                            if (!(src_use && dst_use))
                            begin
                                res_fire   = 1'b1;
                                res_status = ST_REFUSED;
                            end
                            else if (!head.cmd.sym_ok)
                            begin
                                res_fire = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_MODIFY;
                            end
                        end
                        OP_UNLINK_ALL:
                        begin
                            res_fire = 1'b1;
                            if (src_use && dst_use)
                            begin
                                ent_valid_next[hd_src][hd_dst] = 1'b0;
                            end
                            else
                            begin
                                res_status = ST_REFUSED;
                            end
                        end
                        OP_SET_INIT:
                        begin
                            res_fire = 1'b1;
                            if (dst_use)
                            begin
                                init_slot_next  = hd_dst;
                                init_valid_next = 1'b1;
                            end
                            else
                            begin
                                res_status = ST_REFUSED;
                            end
                        end
                        OP_TOGGLE_FINAL:
                        begin
                            res_fire = 1'b1;
                            if (dst_use)
                            begin
                                final_next[hd_dst] = !final_reg[hd_dst];
                            end
                            else
                            begin
                                res_status = ST_REFUSED;
                            end
                        end
                        OP_RUN_START:
                        begin
                            res_fire     = 1'b1;
                            run_set_next = '0;
                            if (init_valid_reg)
                            begin
                                run_set_next[init_slot_reg] = 1'b1;
                            end
                            else
                            begin
                                res_status = ST_NO_INIT;
                            end
                        end
                        OP_RUN_SYMBOL:
                        begin
                            if (!head.cmd.sym_ok)
                            begin
                                res_fire     = 1'b1;
                                run_set_next = '0;
                            end
                            else
                            begin
                                scan_idx_next = '0;
                                pend_next     = 1'b0;
                                acc_next      = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        OP_RUN_END:
                        begin
                            res_fire = 1'b1;
                            if (!init_valid_reg)
                            begin
                                res_status = ST_NO_INIT;
                            end
                            else if ((run_set_reg & final_reg) == '0)
                            begin
                                res_status = ST_REJECTED;
                            end
                        end
                        default:
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_REFUSED;
                        end
                    endcase
                end
            end
            S_MODIFY:
            begin
                // Write back the merged row once the result register can take the word
                if (out_free)
                begin
                    mem_we                           = 1'b1;
                    ent_valid_next[cur_src][cur_dst] = 1'b1;
                    res_fire                         = 1'b1;
                    state_next                       = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // Read one row per cycle, fold in the row read the cycle before
                mem_re        = 1'b1;
                mem_raddr     = scan_idx_reg;
                pend_next     = 1'b1;
                pend_row_next = scan_idx_reg;
                acc_next      = acc_reg | contrib;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_SCAN_END:
            begin
                if (out_free)
                begin
                    run_set_next = acc_reg | contrib;
                    pend_next    = 1'b0;
                    res_fire     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Row memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            row_rd_reg <= row_mem[mem_raddr];
        end
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            active_reg     <= '0;
            final_reg      <= '0;
            init_slot_reg  <= '0;
            init_valid_reg <= 1'b0;
            run_set_reg    <= '0;
            ent_valid_reg  <= '{default: '0};
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_row_reg   <= '0;
            acc_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_slot_reg   <= '0;
            rsp_set_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            active_reg     <= active_next;
            final_reg      <= final_next;
            init_slot_reg  <= init_slot_next;
            init_valid_reg <= init_valid_next;
            run_set_reg    <= run_set_next;
            ent_valid_reg  <= ent_valid_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            pend_row_reg   <= pend_row_next;
            acc_reg        <= acc_next;
            if (res_fire)
            begin
                rsp_valid_reg  <= 1'b1;
                rsp_status_reg <= res_status;
                rsp_slot_reg   <= res_slot;
                rsp_set_reg    <= SET_OUT_W'(run_set_next);
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/nfa_table_acceptor.sv */
// Automaton table acceptor: front decoder, command queue, execution back end.
// Link add/remove is a row read-modify-write; a run symbol step scans every row.
// Throughput: one word per cycle for most operations while the result register is
// free and the queue holds a word; a run symbol step holds the back end for one
// transition row memory read per slot, and a link edit for its read-modify-write.
// Reset (rst_n low, asynchronous): all slots inactive, no initial slot, empty run set, and
// every transition entry marked empty by its flag, so no clearing pass is needed.
`default_nettype none

module nfa_table_acceptor #(
    parameter int NUM_SLOTS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    nta_req_if.sink     req,
    nta_rsp_if.source   rsp
);
    import nta_pkg::*;

    q_entry_t push;
    logic     push_ready;
    q_entry_t head;
    logic     pop;

    nta_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .req        (req),
        .push       (push),
        .push_ready (push_ready)
    );

    nta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    nta_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
